FILE: hw/rtl/acp_pkg.sv
// Shared types, constants and AES helper functions for the CBC/PKCS#7 engine.
package acp_pkg;

    localparam int          BLK_BYTES = 16;
    localparam int          NROUNDS   = 10;
    localparam logic [7:0]  PAD_FULL  = 8'h10;
    localparam logic [4:0]  FULL_CNT  = 5'd16;

    localparam logic [1:0]  ST_OK      = 2'd0;
    localparam logic [1:0]  ST_LEN_ERR = 2'd1;
    localparam logic [1:0]  ST_PAD_ERR = 2'd2;

    typedef enum logic [2:0]
    {
        REG_KEY_HIGH     = 3'd0,
        REG_KEY_LOW      = 3'd1,
        REG_IV_HIGH      = 3'd2,
        REG_IV_LOW       = 3'd3,
        REG_DECRYPT_MODE = 3'd4
    } reg_idx_t;

    typedef logic [127:0] blk_t;
    typedef logic [7:0]   byte_tab_t [256];

    typedef struct packed
    {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        final_block;
    } in_item_t;

    typedef struct packed
    {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_bytes;
        logic [1:0]  status;
        logic        end_of_message;
    } out_item_t;

    typedef enum logic [3:0]
    {
        OP_NOP,
        OP_KEY_INIT,
        OP_KEY_STEP,
        OP_LOAD,
        OP_ENC_START,
        OP_PAD_START,
        OP_DEC_START,
        OP_ENC_ROUND,
        OP_DEC_ROUND,
        OP_ENC_DONE,
        OP_DEC_DONE,
        OP_LEN_ERR
    } dp_op_t;

    typedef struct packed
    {
        dp_op_t     op;
        logic [3:0] rnd;
        logic       chain_init;
        logic       eom;
        logic       in_ready;
    } dp_cmd_t;

    typedef struct packed
    {
        logic in_valid;
        logic decrypt_mode;
        logic key_write;
        logic fin;
        logic extra;
        logic len_ok;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_KEXP,
        S_START,
        S_ROUND,
        S_DONE,
        S_PAD
    } ctrl_state_t;

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        logic [7:0] y;
        r = 8'h00;
        x = a;
        y = b;
        for (int i = 0; i < 8; i++)
        begin
            if (y[0])
            begin
                r = r ^ x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
            y = {1'b0, y[7:1]};
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_inv(logic [7:0] x);
        logic [7:0] r;
        logic [7:0] t;
        r = 8'h01;
        t = x;
        for (int i = 1; i < 8; i++)
        begin
            t = gf_mul(t, t);
            r = gf_mul(r, t);
        end
        return (x != 8'h00) ? r : 8'h00;
    endfunction

    function automatic logic [7:0] rotl8(logic [7:0] x, int n);
        return 8'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic logic [7:0] sbox_calc(logic [7:0] x);
        logic [7:0] v;
        v = gf_inv(x);
        return v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(logic [7:0] y);
        return gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
    endfunction

    function automatic byte_tab_t gen_sbox();
        byte_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = sbox_calc(8'(i));
        end
        return t;
    endfunction

    function automatic byte_tab_t gen_inv_sbox();
        byte_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = inv_sbox_calc(8'(i));
        end
        return t;
    endfunction

    localparam byte_tab_t SBOX     = gen_sbox();
    localparam byte_tab_t INV_SBOX = gen_inv_sbox();

    // byte 0 sits in the top bits
    function automatic logic [7:0] bget(blk_t s, int i);
        return s[8*(15-i) +: 8];
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    endfunction

    function automatic blk_t sub_bytes(blk_t s);
        blk_t o;
        for (int i = 0; i < BLK_BYTES; i++)
        begin
            o[8*i +: 8] = SBOX[s[8*i +: 8]];
        end
        return o;
    endfunction

    function automatic blk_t inv_sub_bytes(blk_t s);
        blk_t o;
        for (int i = 0; i < BLK_BYTES; i++)
        begin
            o[8*i +: 8] = INV_SBOX[s[8*i +: 8]];
        end
        return o;
    endfunction

    function automatic blk_t shift_rows(blk_t s);
        blk_t o;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                o[8*(15-(r+4*c)) +: 8] = bget(s, r + 4*((c + r) & 3));
            end
        end
        return o;
    endfunction

    function automatic blk_t inv_shift_rows(blk_t s);
        blk_t o;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                o[8*(15-(r+4*((c+r)&3))) +: 8] = bget(s, r + 4*c);
            end
        end
        return o;
    endfunction

    function automatic blk_t mix_cols(blk_t s);
        blk_t       o;
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = bget(s, 4*c);
            a1 = bget(s, 4*c + 1);
            a2 = bget(s, 4*c + 2);
            a3 = bget(s, 4*c + 3);
            o[8*(15-4*c) +: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[8*(15-4*c-1) +: 8]   = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[8*(15-4*c-2) +: 8]   = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[8*(15-4*c-3) +: 8]   = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return o;
    endfunction

    function automatic blk_t inv_mix_cols(blk_t s);
        blk_t       o;
        logic [7:0] m [4];
        logic [7:0] v;
        m[0] = 8'd14;
        m[1] = 8'd11;
        m[2] = 8'd13;
        m[3] = 8'd9;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int j = 0; j < 4; j++)
                begin
                    v = v ^ gf_mul(m[(j - r + 4) & 3], bget(s, 4*c + j));
                end
                o[8*(15-(4*c+r)) +: 8] = v;
            end
        end
        return o;
    endfunction

    function automatic blk_t enc_round(blk_t s, blk_t k, logic last);
        blk_t t;
        t = shift_rows(sub_bytes(s));
        if (!last)
        begin
            t = mix_cols(t);
        end
        return t ^ k;
    endfunction

    function automatic blk_t dec_round(blk_t s, blk_t k, logic mix);
        blk_t t;
        t = inv_sub_bytes(inv_shift_rows(s)) ^ k;
        if (mix)
        begin
            t = inv_mix_cols(t);
        end
        return t;
    endfunction

    function automatic logic [7:0] rcon(logic [3:0] rnd);
        logic [7:0] v;
        case (rnd)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic blk_t key_step(blk_t k, logic [7:0] rc);
        logic [31:0] w3;
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        t  = t ^ {rc, 24'h000000};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

FILE: hw/rtl/acp_if.sv
// Request channel interfaces: input blocks, result blocks and register writes.
interface acp_in_if
    import acp_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface acp_out_if
    import acp_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface acp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface

FILE: hw/rtl/acp_datapath.sv
// Datapath: config registers, round keys, AES round unit, chaining and output register.
module acp_datapath
    import acp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    acp_in_if.sink        src,
    acp_out_if.source     dst,
    acp_cfg_if.sink       cfg,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] iv_high_reg;
    logic [63:0] iv_low_reg;
    logic        mode_reg;

    blk_t        rk_reg [NROUNDS+1];
    blk_t        rk_next;
    logic        rk_we;

    blk_t        state_reg;
    blk_t        state_next;
    blk_t        chain_reg;
    blk_t        chain_next;
    in_item_t    in_reg;
    in_item_t    in_next;
    out_item_t   out_reg;
    out_item_t   out_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    blk_t        in_blk;
    blk_t        padded;
    blk_t        rk_sel;
    blk_t        plain;
    blk_t        stripped;
    logic [7:0]  pad_val;
    logic [7:0]  pad_fill;
    logic        pad_ok;
    logic        cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;
    assign src.ready = cmd.in_ready;
    assign dst.valid = out_valid_reg;
    assign dst.item  = out_reg;

    assign in_blk = {in_reg.data_high, in_reg.data_low};
    assign rk_sel = rk_reg[cmd.rnd];
    assign plain  = state_reg ^ chain_reg;

    assign stat.in_valid     = src.valid;
    assign stat.decrypt_mode = mode_reg;
    assign stat.key_write    = cfg_wr && ((cfg.index == REG_KEY_HIGH) ||
                                          (cfg.index == REG_KEY_LOW));
    assign stat.fin          = in_reg.final_block;
    assign stat.extra        = in_reg.final_block && (in_reg.byte_count >= FULL_CNT);
    assign stat.len_ok       = (in_reg.byte_count == FULL_CNT);
    assign stat.out_free     = !out_valid_reg || dst.ready;

    // PKCS#7 fill of a short final block
    always_comb
    begin
        pad_fill = 8'(FULL_CNT - in_reg.byte_count);
        for (int i = 0; i < BLK_BYTES; i++)
        begin
            if (in_reg.final_block && (in_reg.byte_count < FULL_CNT) &&
                (5'(i) >= in_reg.byte_count))
            begin
                padded[8*(15-i) +: 8] = pad_fill;
            end
            else
            begin
                padded[8*(15-i) +: 8] = bget(in_blk, i);
            end
        end
    end

    // padding check and strip on the final decrypted block
    always_comb
    begin
        pad_val = plain[7:0];
        pad_ok  = (pad_val >= 8'd1) && (pad_val <= 8'd16);
        for (int i = 0; i < BLK_BYTES; i++)
        begin
            if ((8'(i) < pad_val) && (bget(plain, 15 - i) != pad_val))
            begin
                pad_ok = 1'b0;
            end
            if (8'(i) >= (8'd16 - pad_val))
            begin
                stripped[8*(15-i) +: 8] = 8'h00;
            end
            else
            begin
                stripped[8*(15-i) +: 8] = bget(plain, i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        in_next        = in_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !dst.ready;
        rk_next        = state_reg;
        rk_we          = 1'b0;
        case (cmd.op)
            OP_KEY_INIT:
            begin
                rk_next    = {key_high_reg, key_low_reg};
                rk_we      = 1'b1;
                state_next = {key_high_reg, key_low_reg};
            end
            OP_KEY_STEP:
            begin
                rk_next    = key_step(state_reg, rcon(cmd.rnd));
                rk_we      = 1'b1;
                state_next = rk_next;
            end
            OP_LOAD:
            begin
                in_next = src.item;
                if (cmd.chain_init)
                begin
                    chain_next = {iv_high_reg, iv_low_reg};
                end
            end
            OP_ENC_START:
            begin
                state_next = padded ^ chain_reg ^ rk_sel;
            end
            OP_PAD_START:
            begin
                state_next = {BLK_BYTES{PAD_FULL}} ^ chain_reg ^ rk_sel;
            end
            OP_DEC_START:
            begin
                state_next = in_blk ^ rk_sel;
            end
            OP_ENC_ROUND:
            begin
                state_next = enc_round(state_reg, rk_sel, cmd.rnd == 4'(NROUNDS));
            end
            OP_DEC_ROUND:
            begin
                state_next = dec_round(state_reg, rk_sel, cmd.rnd != 4'd0);
            end
            OP_ENC_DONE:
            begin
                chain_next     = state_reg;
                out_next       = '{state_reg[127:64], state_reg[63:0], FULL_CNT, ST_OK,
                                   cmd.eom};
                out_valid_next = 1'b1;
            end
            OP_DEC_DONE:
            begin
                chain_next     = in_blk;
                out_valid_next = 1'b1;
                if (!in_reg.final_block)
                begin
                    out_next = '{plain[127:64], plain[63:0], FULL_CNT, ST_OK, 1'b0};
                end
                else if (pad_ok)
                begin
                    out_next = '{stripped[127:64], stripped[63:0],
                                 FULL_CNT - pad_val[4:0], ST_OK, 1'b1};
                end
                else
                begin
                    out_next = '{64'd0, 64'd0, 5'd0, ST_PAD_ERR, 1'b1};
                end
            end
            OP_LEN_ERR:
            begin
                out_next       = '{64'd0, 64'd0, 5'd0, ST_LEN_ERR, in_reg.final_block};
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            iv_high_reg   <= '0;
            iv_low_reg    <= '0;
            mode_reg      <= 1'b0;
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                case (cfg.index)
                    REG_KEY_HIGH:     key_high_reg <= cfg.value;
                    REG_KEY_LOW:      key_low_reg  <= cfg.value;
                    REG_IV_HIGH:      iv_high_reg  <= cfg.value;
                    REG_IV_LOW:       iv_low_reg   <= cfg.value;
                    REG_DECRYPT_MODE: mode_reg     <= cfg.value[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        in_reg    <= in_next;
        out_reg   <= out_next;
        if (rk_we)
        begin
            rk_reg[cmd.rnd] <= rk_next;
        end
    end

endmodule

FILE: hw/rtl/acp_ctrl.sv
// Controller: sequences key expansion, rounds, padding block and result hand-off.
module acp_ctrl
    import acp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_stat_t  stat,
    output dp_cmd_t   cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        keys_ready_reg;
    logic        keys_ready_next;
    logic        in_msg_reg;
    logic        in_msg_next;
    logic        pad_phase_reg;
    logic        pad_phase_next;
    logic        accept;

    assign accept = (state_reg == S_IDLE) && stat.in_valid;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        keys_ready_next = keys_ready_reg && !stat.key_write;
        in_msg_next     = in_msg_reg;
        pad_phase_next  = pad_phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    in_msg_next    = 1'b1;
                    pad_phase_next = 1'b0;
                    cnt_next       = 4'd0;
                    state_next     = keys_ready_reg ? S_START : S_KEXP;
                end
            end
            S_KEXP:
            begin
                if (cnt_reg == 4'(NROUNDS))
                begin
                    keys_ready_next = 1'b1;
                    state_next      = S_START;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_START:
            begin
                if (!stat.decrypt_mode)
                begin
                    cnt_next   = 4'd1;
                    state_next = S_ROUND;
                end
                else if (stat.len_ok)
                begin
                    cnt_next   = 4'(NROUNDS - 1);
                    state_next = S_ROUND;
                end
                else if (stat.out_free)
                begin
                    if (stat.fin)
                    begin
                        in_msg_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ROUND:
            begin
                if (!stat.decrypt_mode)
                begin
                    if (cnt_reg == 4'(NROUNDS))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                else if (cnt_reg == 4'd0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    if (!stat.decrypt_mode && stat.extra && !pad_phase_reg)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        if (stat.fin)
                        begin
                            in_msg_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_PAD:
            begin
                pad_phase_next = 1'b1;
                cnt_next       = 4'd1;
                state_next     = S_ROUND;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.op         = OP_NOP;
        cmd.rnd        = cnt_reg;
        cmd.chain_init = !in_msg_reg;
        cmd.eom        = stat.fin && (!stat.extra || pad_phase_reg);
        cmd.in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_KEXP:
            begin
                cmd.op = (cnt_reg == 4'd0) ? OP_KEY_INIT : OP_KEY_STEP;
            end
            S_START:
            begin
                if (!stat.decrypt_mode)
                begin
                    cmd.op  = OP_ENC_START;
                    cmd.rnd = 4'd0;
                end
                else if (stat.len_ok)
                begin
                    cmd.op  = OP_DEC_START;
                    cmd.rnd = 4'(NROUNDS);
                end
                else if (stat.out_free)
                begin
                    cmd.op = OP_LEN_ERR;
                end
            end
            S_ROUND:
            begin
                cmd.op = stat.decrypt_mode ? OP_DEC_ROUND : OP_ENC_ROUND;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op = stat.decrypt_mode ? OP_DEC_DONE : OP_ENC_DONE;
                end
            end
            S_PAD:
            begin
                cmd.op  = OP_PAD_START;
                cmd.rnd = 4'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= 4'd0;
            keys_ready_reg <= 1'b0;
            in_msg_reg     <= 1'b0;
            pad_phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            keys_ready_reg <= keys_ready_next;
            in_msg_reg     <= in_msg_next;
            pad_phase_reg  <= pad_phase_next;
        end
    end

`ifndef ASSERT_OFF
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (cnt_reg <= 4'(NROUNDS)))
        else $error("round counter out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ENC_DONE || cmd.op == OP_DEC_DONE || cmd.op == OP_LEN_ERR)
        |-> stat.out_free)
        else $error("result register overwritten");

    a_keys_before_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) |-> keys_ready_reg)
        else $error("block started without round keys");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("request accepted but not processed");
`endif

endmodule

FILE: hw/rtl/aes128_cbc_pkcs7_engine.sv
// Top level: AES-128 CBC engine with PKCS#7 padding, controller plus datapath.
// Per block, from acceptance to the next acceptance: load, start, ten one-round-per-cycle
//   steps and result (the result waits for a free output register); the single AES round
//   unit takes one block at a time. A full final encrypt block adds a pad block; a length error skips the rounds.
// After a key write the first block is preceded by key expansion.
// Reset (rst_n, async low) clears config, chain value and control; round keys are rebuilt.
module aes128_cbc_pkcs7_engine
    import acp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    acp_in_if.sink     src,
    acp_out_if.source  dst,
    acp_cfg_if.sink    cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    acp_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    acp_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src),
        .dst   (dst),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
